[src/plti_pkg.sv]
package plti_pkg;

  // Q16.16 one.
  localparam logic signed [31:0] Q_ONE = 32'sd65536;

  // Quotient magnitude limit of the multiply-divide unit.
  localparam logic [63:0] MD_LIMIT = 64'h0000_0100_0000_0000;

  // Result status codes.
  localparam logic [2:0] STAT_STORED = 3'd0;
  localparam logic [2:0] STAT_FULL   = 3'd1;
  localparam logic [2:0] STAT_EMPTY  = 3'd2;
  localparam logic [2:0] STAT_BELOW  = 3'd3;
  localparam logic [2:0] STAT_INSIDE = 3'd4;
  localparam logic [2:0] STAT_ABOVE  = 3'd5;

  // Request kinds.
  localparam logic REQ_APPEND = 1'b0;
  localparam logic REQ_QUERY  = 1'b1;

  // Lookup modes.
  localparam logic [1:0] MODE_ZERO   = 2'd0;
  localparam logic [1:0] MODE_CLAMP  = 2'd1;
  localparam logic [1:0] MODE_SLOPE  = 2'd2;
  localparam logic [1:0] MODE_EXTRAP = 2'd3;

  // Operands of one multiply-divide: trunc(a * b / d).
  typedef struct packed {
    logic signed [32:0] a;
    logic signed [32:0] b;
    logic signed [32:0] d;
  } md_req_t;

  typedef enum logic [1:0] {
    MD_IDLE,
    MD_MUL,
    MD_DIV,
    MD_OUT
  } md_state_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FIRST,
    ST_DOWN,
    ST_UP,
    ST_VAL,
    ST_PAIR_LO,
    ST_PAIR_HI,
    ST_SETUP,
    ST_MUL_VAL,
    ST_MUL_SLOPE,
    ST_FINISH
  } plti_state_t;

  // Saturate a wide signed value to 32 bits.
  function automatic logic signed [31:0] sat32(input logic signed [42:0] x);
    logic signed [31:0] r;
    if (x > 43'sd2147483647) begin
      r = 32'sh7FFF_FFFF;
    end else if (x < -43'sd2147483648) begin
      r = 32'sh8000_0000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

endpackage

[src/plti_store.sv]
module plti_store #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [31:0]   wtime,
  input  logic [31:0]   wvalue,
  input  logic [AW-1:0] raddr,
  output logic [31:0]   rtime,
  output logic [31:0]   rvalue
);

  logic [31:0] time_mem  [DEPTH];
  logic [31:0] value_mem [DEPTH];

  // One write port and one registered read port, shared by both arrays.
  always_ff @(posedge clk) begin
    if (we) begin
      time_mem[waddr]  <= wtime;
      value_mem[waddr] <= wvalue;
    end
    rtime  <= time_mem[raddr];
    rvalue <= value_mem[raddr];
  end

endmodule

[src/plti_muldiv.sv]
module plti_muldiv
  import plti_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  md_req_t            req,
  output logic               done,
  output logic signed [41:0] result
);

  md_state_t   st_r, st_nxt;
  logic [31:0] ma_r, ma_nxt;
  logic [31:0] mb_r, mb_nxt;
  logic [31:0] md_r, md_nxt;
  logic        neg_r, neg_nxt;
  logic [31:0] rem_r, rem_nxt;
  logic [63:0] dq_r, dq_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic [63:0] prod;
  logic [32:0] shifted;
  logic [33:0] diff;
  logic [40:0] qsat;

  function automatic logic [31:0] mag(input logic signed [32:0] x);
    logic signed [32:0] n;
    n = -x;
    return x[32] ? n[31:0] : x[31:0];
  endfunction

  assign prod    = ma_r * mb_r;
  assign shifted = {rem_r, dq_r[63]};
  assign diff    = {1'b0, shifted} - {2'b00, md_r};

  // Saturate the quotient magnitude, then apply the sign.
  assign qsat   = (dq_r > MD_LIMIT) ? MD_LIMIT[40:0] : dq_r[40:0];
  assign result = neg_r ? -$signed({1'b0, qsat}) : $signed({1'b0, qsat});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= MD_IDLE;
    end else begin
      st_r <= st_nxt;
    end
    ma_r  <= ma_nxt;
    mb_r  <= mb_nxt;
    md_r  <= md_nxt;
    neg_r <= neg_nxt;
    rem_r <= rem_nxt;
    dq_r  <= dq_nxt;
    cnt_r <= cnt_nxt;
  end

  // Sequencer: latch magnitudes, multiply once, then one quotient bit a cycle.
  always_comb begin
    st_nxt  = st_r;
    ma_nxt  = ma_r;
    mb_nxt  = mb_r;
    md_nxt  = md_r;
    neg_nxt = neg_r;
    rem_nxt = rem_r;
    dq_nxt  = dq_r;
    cnt_nxt = cnt_r;
    done    = 1'b0;
    case (st_r)
      MD_IDLE: begin
        if (start) begin
          ma_nxt  = mag(req.a);
          mb_nxt  = mag(req.b);
          md_nxt  = mag(req.d);
          neg_nxt = req.a[32] ^ req.b[32] ^ req.d[32];
          st_nxt  = MD_MUL;
        end
      end
      MD_MUL: begin
        dq_nxt  = prod;
        rem_nxt = '0;
        cnt_nxt = '0;
        st_nxt  = MD_DIV;
      end
      MD_DIV: begin
        if (!diff[33]) begin
          rem_nxt = diff[31:0];
          dq_nxt  = {dq_r[62:0], 1'b1};
        end else begin
          rem_nxt = shifted[31:0];
          dq_nxt  = {dq_r[62:0], 1'b0};
        end
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == 6'd63) begin
          st_nxt = MD_OUT;
        end
      end
      MD_OUT: begin
        // A new pass may start in the same cycle the result is taken.
        done = 1'b1;
        if (start) begin
          ma_nxt  = mag(req.a);
          mb_nxt  = mag(req.b);
          md_nxt  = mag(req.d);
          neg_nxt = req.a[32] ^ req.b[32] ^ req.d[32];
          st_nxt  = MD_MUL;
        end else begin
          st_nxt = MD_IDLE;
        end
      end
      default: st_nxt = MD_IDLE;
    endcase
  end

endmodule

[src/piecewise_linear_table_interp_unit.sv]
// Append or full table: the request passes through ST_FINISH to the output register.
// Query: cursor search (ST_FIRST, then ST_DOWN or ST_UP while the cursor moves), then the
// bracketing pair is fetched (ST_PAIR_LO, ST_PAIR_HI, ST_SETUP) and the shared multiply-divide
// unit makes its passes (value, then slope); empty or clamped answers skip the unit.
// One item at a time: the next item can be accepted in the same cycle the result becomes valid.
// Reset (synchronous, rst_n low) clears point count, cursor, mode and output valid.
module piecewise_linear_table_interp_unit
  import plti_pkg::*;
#(
  parameter int MAX_POINTS = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // time_key[31:0], point_value[63:32]
  input  logic        in_tuser,   // req_type
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // value_out[31:0], slope_out[63:32]
  output logic [2:0]  out_tuser,  // status
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_wr_data
);

  localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CW = $clog2(MAX_POINTS + 1);

  plti_state_t        state_r, state_nxt;
  logic [1:0]         mode_r;
  logic [CW-1:0]      cnt_r, cnt_nxt;
  logic [AW-1:0]      cursor_r, cursor_nxt;
  logic [AW-1:0]      c_r, c_nxt;
  logic [AW-1:0]      lo_r, lo_nxt;
  logic               ext_r, ext_nxt;
  logic               slope_need_r, slope_need_nxt;
  logic signed [31:0] t_r, t_nxt;
  logic signed [31:0] t1_r, t1_nxt, t2_r, t2_nxt;
  logic signed [31:0] v1_r, v1_nxt, v2_r, v2_nxt;
  logic signed [31:0] val_r, val_nxt;
  logic signed [31:0] slope_r, slope_nxt;
  logic [2:0]         status_r, status_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [63:0]        out_data_r, out_data_nxt;
  logic [2:0]         out_user_r, out_user_nxt;

  logic               accept;
  logic               we;
  logic [AW-1:0]      rd_addr;
  logic [31:0]        rd_time, rd_value;
  logic signed [31:0] rd_time_s;
  logic [AW-1:0]      nm1, start_raw, c_start, c_inc;
  logic               fin_go, fin_below;
  logic [AW-1:0]      fin_c;
  logic signed [31:0] base;
  logic signed [32:0] dv, dt, dx;
  md_req_t            md_req;
  logic               md_start, md_done;
  logic signed [41:0] md_res;

  assign in_tready  = (state_r == ST_IDLE);
  assign accept     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign rd_time_s  = $signed(rd_time);

  // Search start: the kept cursor in mode zero, else the middle, clamped to the last point.
  assign nm1       = AW'(cnt_r - CW'(1));
  assign start_raw = (mode_r == MODE_ZERO) ? cursor_r : AW'(cnt_r >> 1);
  assign c_start   = (start_raw > nm1) ? nm1 : start_raw;
  assign c_inc     = c_r + AW'(1);

  // Segment operands; the extrapolated case measures from the upper point.
  assign base = ext_r ? v2_r : v1_r;
  assign dv   = $signed({v2_r[31], v2_r}) - $signed({v1_r[31], v1_r});
  assign dt   = $signed({t2_r[31], t2_r}) - $signed({t1_r[31], t1_r});
  assign dx   = ext_r ? ($signed({t_r[31], t_r}) - $signed({t2_r[31], t2_r}))
                      : ($signed({t_r[31], t_r}) - $signed({t1_r[31], t1_r}));

  always_comb begin
    md_req.a = dv;
    md_req.d = dt;
    md_req.b = (state_r == ST_SETUP) ? dx : 33'(Q_ONE);
  end

  plti_store #(
    .DEPTH (MAX_POINTS),
    .AW    (AW)
  ) u_store (
    .clk    (clk),
    .we     (we),
    .waddr  (cnt_r[AW-1:0]),
    .wtime  (in_tdata[31:0]),
    .wvalue (in_tdata[63:32]),
    .raddr  (rd_addr),
    .rtime  (rd_time),
    .rvalue (rd_value)
  );

  plti_muldiv u_muldiv (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (md_start),
    .req    (md_req),
    .done   (md_done),
    .result (md_res)
  );

  // Control and configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      mode_r      <= MODE_ZERO;
      cnt_r       <= '0;
      cursor_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      cursor_r    <= cursor_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        mode_r <= cfg_wr_data;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    c_r          <= c_nxt;
    lo_r         <= lo_nxt;
    ext_r        <= ext_nxt;
    slope_need_r <= slope_need_nxt;
    t_r          <= t_nxt;
    t1_r         <= t1_nxt;
    t2_r         <= t2_nxt;
    v1_r         <= v1_nxt;
    v2_r         <= v2_nxt;
    val_r        <= val_nxt;
    slope_r      <= slope_nxt;
    status_r     <= status_nxt;
    out_data_r   <= out_data_nxt;
    out_user_r   <= out_user_nxt;
  end

  // Sequencer: appends, and for queries cursor search, pair fetch, then value and slope on the shared unit.
  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    cursor_nxt     = cursor_r;
    c_nxt          = c_r;
    lo_nxt         = lo_r;
    ext_nxt        = ext_r;
    slope_need_nxt = slope_need_r;
    t_nxt          = t_r;
    t1_nxt         = t1_r;
    t2_nxt         = t2_r;
    v1_nxt         = v1_r;
    v2_nxt         = v2_r;
    val_nxt        = val_r;
    slope_nxt      = slope_r;
    status_nxt     = status_r;
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    out_user_nxt   = out_user_r;
    we             = 1'b0;
    rd_addr        = c_r;
    md_start       = 1'b0;
    fin_go         = 1'b0;
    fin_below      = 1'b0;
    fin_c          = c_r;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          t_nxt     = $signed(in_tdata[31:0]);
          val_nxt   = '0;
          slope_nxt = '0;
          if (in_tuser == REQ_APPEND) begin
            if (cnt_r >= CW'(MAX_POINTS)) begin
              status_nxt = STAT_FULL;
            end else begin
              we         = 1'b1;
              cnt_nxt    = cnt_r + CW'(1);
              status_nxt = STAT_STORED;
            end
            state_nxt = ST_FINISH;
          end else if (cnt_r == '0) begin
            status_nxt = STAT_EMPTY;
            val_nxt    = (mode_r == MODE_ZERO) ? Q_ONE : '0;
            state_nxt  = ST_FINISH;
          end else begin
            c_nxt     = c_start;
            rd_addr   = c_start;
            state_nxt = ST_FIRST;
          end
        end
      end
      ST_FIRST: begin
        if (rd_time_s > t_r) begin
          if (c_r == '0) begin
            fin_go    = 1'b1;
            fin_below = 1'b1;
          end else begin
            c_nxt     = c_r - AW'(1);
            rd_addr   = c_r - AW'(1);
            state_nxt = ST_DOWN;
          end
        end else if (c_r == nm1) begin
          fin_go = 1'b1;
        end else begin
          rd_addr   = c_inc;
          state_nxt = ST_UP;
        end
      end
      ST_DOWN: begin
        if (rd_time_s > t_r) begin
          if (c_r == '0) begin
            fin_go    = 1'b1;
            fin_below = 1'b1;
          end else begin
            c_nxt   = c_r - AW'(1);
            rd_addr = c_r - AW'(1);
          end
        end else begin
          fin_go = 1'b1;
        end
      end
      ST_UP: begin
        if (rd_time_s < t_r) begin
          c_nxt = c_inc;
          if (c_inc == nm1) begin
            fin_go = 1'b1;
            fin_c  = c_inc;
          end else begin
            rd_addr = c_r + AW'(2);
          end
        end else begin
          fin_go = 1'b1;
        end
      end
      ST_VAL: begin
        val_nxt   = $signed(rd_value);
        state_nxt = ST_FINISH;
      end
      ST_PAIR_LO: begin
        t1_nxt    = rd_time_s;
        v1_nxt    = $signed(rd_value);
        rd_addr   = lo_r + AW'(1);
        state_nxt = ST_PAIR_HI;
      end
      ST_PAIR_HI: begin
        t2_nxt    = rd_time_s;
        v2_nxt    = $signed(rd_value);
        state_nxt = ST_SETUP;
      end
      ST_SETUP: begin
        if (t2_r == t1_r) begin
          val_nxt   = base;
          state_nxt = ST_FINISH;
        end else begin
          md_start  = 1'b1;
          state_nxt = ST_MUL_VAL;
        end
      end
      ST_MUL_VAL: begin
        if (md_done) begin
          val_nxt = sat32(43'(base) + 43'(md_res));
          if (slope_need_r) begin
            md_start  = 1'b1;
            state_nxt = ST_MUL_SLOPE;
          end else begin
            state_nxt = ST_FINISH;
          end
        end
      end
      ST_MUL_SLOPE: begin
        if (md_done) begin
          slope_nxt = sat32(43'(md_res));
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        // Hand the result over once the output register is free.
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {slope_r, val_r};
          out_user_nxt  = status_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    // End of the search: keep the cursor and pick how the answer is formed.
    if (fin_go) begin
      c_nxt      = fin_c;
      cursor_nxt = fin_below ? '0 : fin_c;
      if (fin_below) begin
        status_nxt = STAT_BELOW;
        if (mode_r == MODE_ZERO) begin
          state_nxt = ST_FINISH;
        end else begin
          rd_addr   = '0;
          state_nxt = ST_VAL;
        end
      end else if (fin_c == nm1) begin
        status_nxt = STAT_ABOVE;
        if (mode_r == MODE_ZERO) begin
          state_nxt = ST_FINISH;
        end else if (mode_r == MODE_EXTRAP && cnt_r >= CW'(2)) begin
          lo_nxt         = fin_c - AW'(1);
          ext_nxt        = 1'b1;
          slope_need_nxt = 1'b1;
          rd_addr        = fin_c - AW'(1);
          state_nxt      = ST_PAIR_LO;
        end else begin
          rd_addr   = fin_c;
          state_nxt = ST_VAL;
        end
      end else begin
        status_nxt     = STAT_INSIDE;
        lo_nxt         = fin_c;
        ext_nxt        = 1'b0;
        slope_need_nxt = (mode_r == MODE_SLOPE) || (mode_r == MODE_EXTRAP);
        rd_addr        = fin_c;
        state_nxt      = ST_PAIR_LO;
      end
    end
  end

endmodule

[tb/piecewise_linear_table_interp_unit_test.sv]
module piecewise_linear_table_interp_unit_test;
  import plti_pkg::*;

  localparam int TABLE_DEPTH = 64;
  localparam int IDLE_LIMIT = 20000;
  localparam longint QUOT_CAP = longint'(1) << 40;

  typedef struct {
    logic [31:0] value;
    logic [31:0] slope;
    logic [2:0]  status;
  } answer_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [63:0] in_tdata;   // time_key[31:0], point_value[63:32]
  logic        in_tuser;   // req_type
  logic        out_tvalid;
  logic        out_tready;
  logic [63:0] out_tdata;  // value_out[31:0], slope_out[63:32]
  logic [2:0]  out_tuser;  // status
  logic        cfg_wr_en;
  logic [1:0]  cfg_wr_data;

  // Shadow copy of the table contents, cursor and mode.
  longint      bp_time [TABLE_DEPTH];
  longint      bp_value [TABLE_DEPTH];
  int          bp_count;
  int          cursor_pos;
  logic [1:0]  mode_now;

  answer_t     answers_due [$];
  int          error_count;
  int          results_seen;
  int          queries_sent;
  int          appends_sent;
  int          burst_left;
  int          hold_request;
  int          idle_cycles;

  piecewise_linear_table_interp_unit #(.MAX_POINTS(TABLE_DEPTH)) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Exact trunc(a * b / d), with the quotient magnitude capped at 2^40.
  function automatic longint scaled_ratio(input longint a, input longint b, input longint d);
    logic signed [127:0] prod;
    logic signed [127:0] den;
    logic signed [127:0] quot;
    bit negative;
    prod = a;
    prod = prod * b;
    den = d;
    negative = (prod < 0) != (den < 0);
    if (prod < 0) begin
      prod = -prod;
    end
    if (den < 0) begin
      den = -den;
    end
    quot = prod / den;
    if (quot > QUOT_CAP) begin
      quot = QUOT_CAP;
    end
    return negative ? -longint'(quot) : longint'(quot);
  endfunction

  function automatic longint clip32(input longint x);
    if (x > 64'sd2147483647) begin
      return 64'sd2147483647;
    end
    if (x < -64'sd2147483648) begin
      return -64'sd2147483648;
    end
    return x;
  endfunction

  // Apply one item to the shadow table and work out its answer.
  function automatic answer_t interp_answer(input logic req, input logic [31:0] tk,
                                            input logic [31:0] pv);
    answer_t ans;
    longint t;
    longint val;
    longint slope;
    longint t1;
    longint t2;
    longint v1;
    longint v2;
    int c;
    int n;
    t = longint'($signed(tk));
    val = 0;
    slope = 0;
    n = bp_count;
    if (req == REQ_APPEND) begin
      if (bp_count >= TABLE_DEPTH) begin
        ans.status = STAT_FULL;
      end else begin
        bp_time[bp_count] = t;
        bp_value[bp_count] = longint'($signed(pv));
        bp_count++;
        ans.status = STAT_STORED;
      end
    end else if (n == 0) begin
      val = (mode_now == MODE_ZERO) ? longint'(Q_ONE) : 0;
      ans.status = STAT_EMPTY;
    end else begin
      c = (mode_now == MODE_ZERO) ? cursor_pos : n / 2;
      if (c > n - 1) begin
        c = n - 1;
      end
      // Walk down while the stored time is past the key, else walk up.
      if (bp_time[c] > t) begin
        while (c >= 0 && bp_time[c] > t) c--;
      end else begin
        while (c < n - 1 && bp_time[c + 1] < t) c++;
      end
      cursor_pos = (c < 0) ? 0 : c;
      if (c < 0) begin
        ans.status = STAT_BELOW;
        val = (mode_now == MODE_ZERO) ? 0 : bp_value[0];
      end else if (c == n - 1) begin
        ans.status = STAT_ABOVE;
        if (mode_now == MODE_ZERO) begin
          val = 0;
        end else if (mode_now == MODE_EXTRAP && n >= 2) begin
          t1 = bp_time[c - 1];
          t2 = bp_time[c];
          v1 = bp_value[c - 1];
          v2 = bp_value[c];
          val = v2;
          if (t2 != t1) begin
            slope = clip32(scaled_ratio(v2 - v1, longint'(Q_ONE), t2 - t1));
            val = v2 + scaled_ratio(v2 - v1, t - t2, t2 - t1);
          end
        end else begin
          val = bp_value[c];
        end
      end else begin
        t1 = bp_time[c];
        t2 = bp_time[c + 1];
        v1 = bp_value[c];
        v2 = bp_value[c + 1];
        ans.status = STAT_INSIDE;
        val = v1;
        if (t2 != t1) begin
          val = v1 + scaled_ratio(v2 - v1, t - t1, t2 - t1);
          if (mode_now >= MODE_SLOPE) begin
            slope = clip32(scaled_ratio(v2 - v1, longint'(Q_ONE), t2 - t1));
          end
        end
      end
    end
    ans.value = 32'(clip32(val));
    ans.slope = 32'(slope);
    return ans;
  endfunction

  // Offer one item, in bursts with random gaps, and record its answer once taken.
  task automatic send_item(input logic req, input logic [31:0] tk, input logic [31:0] pv);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 6);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(1, 12);
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tuser <= req;
    in_tdata <= {pv, tk};
    do @(posedge clk); while (!in_tready);
    answers_due.push_back(interp_answer(req, tk, pv));
    if (req == REQ_QUERY) begin
      queries_sent++;
    end else begin
      appends_sent++;
    end
  endtask

  // Stop offering and let every outstanding answer come back.
  task automatic drain_all();
    in_tvalid <= 1'b0;
    while (answers_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_mode(input logic [1:0] m);
    drain_all();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= m;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    mode_now = m;
  endtask

  // Pick a query time near the stored breakpoints, on them, at either extreme, or anywhere.
  function automatic logic [31:0] pick_key();
    int k;
    int sel;
    sel = $urandom_range(0, 99);
    if (bp_count == 0 || sel < 15) begin
      return $urandom();
    end
    k = $urandom_range(0, bp_count - 1);
    if (sel < 35) begin
      return 32'(bp_time[k]);
    end
    if (sel < 45) begin
      return ($urandom_range(0, 1) != 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
    end
    return 32'(bp_time[k] + longint'($signed(32'($urandom_range(0, 32'h0020_0000)))));
  endfunction

  task automatic test_empty_table();
    for (int m = 0; m < 4; m++) begin
      set_mode(2'(m));
      send_item(REQ_QUERY, 32'h0000_0000, 32'hFFFF_FFFF);
      send_item(REQ_QUERY, 32'h8000_0000, 32'h0000_0000);
    end
  endtask

  // One point: below, on and above it, including the extrapolation mode.
  task automatic test_single_point();
    set_mode(MODE_ZERO);
    send_item(REQ_APPEND, 32'h0001_0000, 32'h0003_0000);
    for (int m = 0; m < 4; m++) begin
      set_mode(2'(m));
      send_item(REQ_QUERY, 32'h0000_0000, 32'h0);
      send_item(REQ_QUERY, 32'h0001_0000, 32'h0);
      send_item(REQ_QUERY, 32'h7FFF_FFFF, 32'h0);
    end
  endtask

  // Steep segments at both ends, an equal-time pair and one point out of order.
  task automatic test_fill_table();
    logic [31:0] tk;
    set_mode(MODE_EXTRAP);
    send_item(REQ_APPEND, 32'h0001_0001, 32'h8000_0000);
    send_item(REQ_APPEND, 32'h0002_0000, 32'h7FFF_FFFF);
    send_item(REQ_QUERY, 32'h0001_8000, 32'h0);
    send_item(REQ_QUERY, 32'h7FFF_FFFF, 32'h0);
    tk = 32'h0003_0000;
    while (bp_count < TABLE_DEPTH - 1) begin
      if (bp_count == 20) begin
        send_item(REQ_APPEND, tk, $urandom());
      end else if (bp_count == 40) begin
        send_item(REQ_APPEND, tk - 32'h0000_8000, $urandom());
      end else begin
        tk = tk + $urandom_range(1, 32'h0100_0000);
        send_item(REQ_APPEND, tk, $urandom());
      end
      if ($urandom_range(0, 2) == 0) begin
        set_mode(2'($urandom_range(0, 3)));
        send_item(REQ_QUERY, pick_key(), $urandom());
      end
    end
    send_item(REQ_APPEND, 32'h7FFF_FFFF, 32'h8000_0000);
    send_item(REQ_QUERY, 32'h7FFF_FFFF, 32'h0);
    send_item(REQ_APPEND, $urandom(), $urandom());
  endtask

  // Receiver stalls until the input side backs up, then the sender waits for all.
  task automatic test_backpressure();
    set_mode(MODE_SLOPE);
    hold_request = 1;
    repeat (6) send_item(REQ_QUERY, pick_key(), $urandom());
    drain_all();
  endtask

  task automatic test_random_traffic();
    for (int i = 0; i < 1400; i++) begin
      if (i % 150 == 0) begin
        set_mode(2'($urandom_range(0, 3)));
      end
      if ($urandom_range(0, 9) == 0) begin
        send_item(REQ_APPEND, $urandom(), $urandom());
      end else begin
        send_item(REQ_QUERY, pick_key(), $urandom());
      end
    end
    drain_all();
  endtask

  // Receiver: a long hold on request, else windows chosen at random to be clean or stalling.
  int hold_left;
  int window_pos;
  bit window_stalls;
  always @(posedge clk) begin
    if (hold_request != 0) begin
      hold_request <= 0;
      hold_left <= 600;
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      if (window_pos == 0) begin
        window_stalls <= $urandom_range(0, 1);
      end
      window_pos <= (window_pos + 1) % 64;
      out_tready <= !(window_stalls && $urandom_range(0, 99) < 40);
    end
  end

  // Compare each answer with the oldest one due.
  always @(posedge clk) begin
    answer_t due;
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (answers_due.size() == 0) begin
        $error("unexpected result value=%h slope=%h status=%0d",
               out_tdata[31:0], out_tdata[63:32], out_tuser);
        error_count++;
      end else begin
        due = answers_due.pop_front();
        if (out_tdata[31:0] !== due.value) begin
          $error("value_out expected %h actual %h", due.value, out_tdata[31:0]);
          error_count++;
        end
        if (out_tdata[63:32] !== due.slope) begin
          $error("slope_out expected %h actual %h", due.slope, out_tdata[63:32]);
          error_count++;
        end
        if (out_tuser !== due.status) begin
          $error("status expected %0d actual %0d", due.status, out_tuser);
          error_count++;
        end
      end
    end
  end

  // Watchdog on cycles without any item moving.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !rst_n) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles > IDLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = 1'b0;
    out_tready = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    bp_count = 0;
    cursor_pos = 0;
    mode_now = MODE_ZERO;
    error_count = 0;
    results_seen = 0;
    queries_sent = 0;
    appends_sent = 0;
    burst_left = 0;
    hold_request = 0;
    hold_left = 0;
    window_pos = 0;
    window_stalls = 1'b0;
    idle_cycles = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_table();
    test_single_point();
    test_fill_table();
    test_backpressure();
    test_random_traffic();
    drain_all();
    repeat (250) @(posedge clk);

    $display("Checked %0d results: %0d queries and %0d appends over all four modes,",
             results_seen, queries_sent, appends_sent);
    $display("from an empty table through a full one, with stalls on both sides.");
    if (error_count == 0 && answers_due.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
